// ----- design/pdpd_pkg.sv -----
// ----------------------------------------------------------------------------
// Pulse-distance packet decoder package
// Shared widths, phase codes, register indexes and the window-match struct.
// ----------------------------------------------------------------------------
package pdpd_pkg;

    localparam int PACKET_BITS = 36;
    localparam int CNT_W       = $clog2(PACKET_BITS + 1);
    localparam int TIME_W      = 16;
    localparam int TOL_W       = 10;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    // Signed compare width: room for nominal + tolerance and a negative low edge.
    localparam int WIN_W       = TIME_W + 2;

    localparam logic [1:0] PH_UNKNOWN = 2'd0;
    localparam logic [1:0] PH_START   = 2'd1;
    localparam logic [1:0] PH_END     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_PULSE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_GAP   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_GAP    = 2'd3;

    localparam logic [TOL_W-1:0]  TOLERANCE_RST  = 10'd100;
    localparam logic [TIME_W-1:0] HIGH_PULSE_RST = 16'd500;
    localparam logic [TIME_W-1:0] ZERO_GAP_RST   = 16'd1000;
    localparam logic [TIME_W-1:0] ONE_GAP_RST    = 16'd2000;

    typedef struct packed {
        logic high_ok;
        logic zero_ok;
        logic one_ok;
    } pdpd_match_t;

endpackage

// ----- design/pdpd_window.sv -----
// ----------------------------------------------------------------------------
// Pulse length window check
// True when the interval lies strictly inside nominal +/- tolerance (signed).
// ----------------------------------------------------------------------------
module pdpd_window
    import pdpd_pkg::*;
(
    input  logic [TIME_W-1:0] interval,
    input  logic [TIME_W-1:0] nominal,
    input  logic [TOL_W-1:0]  tolerance,
    output logic              ok
);

    logic signed [WIN_W-1:0] t_s;
    logic signed [WIN_W-1:0] n_s;
    logic signed [WIN_W-1:0] tol_s;
    logic signed [WIN_W-1:0] hi_s;
    logic signed [WIN_W-1:0] lo_s;

    assign t_s   = signed'({2'b00, interval});
    assign n_s   = signed'({2'b00, nominal});
    assign tol_s = signed'({{(WIN_W - TOL_W){1'b0}}, tolerance});
    assign hi_s  = n_s + tol_s;
    assign lo_s  = n_s - tol_s;
    assign ok    = (t_s < hi_s) && (t_s > lo_s);

endmodule

// ----- design/pdpd_core.sv -----
// ----------------------------------------------------------------------------
// Pulse-distance decoder core
// Phase machine, bit counter and MSB-first shift register; one edge per step.
// ----------------------------------------------------------------------------
module pdpd_core
    import pdpd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic                   rising,
    input  pdpd_match_t            match,
    output logic                   emit,
    output logic [PACKET_BITS-1:0] packet_data
);

    logic [1:0]             phase_reg;
    logic [1:0]             phase_next;
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       cnt_next;
    logic [PACKET_BITS-1:0] shift_reg;
    logic [PACKET_BITS-1:0] shift_next;
    logic                   shift_en;
    logic                   shift_bit;
    logic                   clear_bits;
    logic [CNT_W-1:0]       cnt_inc;
    logic [PACKET_BITS-1:0] shift_in;

    always_comb
    begin
        phase_next = PH_UNKNOWN;
        shift_en   = 1'b0;
        shift_bit  = 1'b0;
        clear_bits = 1'b0;
        unique case (phase_reg)
            PH_START:
            begin
                phase_next = (!rising && match.high_ok) ? PH_END : PH_UNKNOWN;
            end
            PH_END:
            begin
                if (rising)
                begin
                    phase_next = PH_START;
                    if (match.one_ok)
                    begin
                        shift_en  = 1'b1;
                        shift_bit = 1'b1;
                    end
                    else if (match.zero_ok)
                    begin
                        shift_en = 1'b1;
                    end
                    else
                    begin
                        clear_bits = 1'b1;
                    end
                end
            end
            default:
            begin
                phase_next = rising ? PH_START : PH_UNKNOWN;
            end
        endcase
    end

    assign cnt_inc  = cnt_reg + CNT_W'(1);
    assign shift_in = (shift_reg << 1) | PACKET_BITS'(shift_bit);
    assign emit     = shift_en && (cnt_inc == CNT_W'(PACKET_BITS));
    assign packet_data = shift_in;

    always_comb
    begin
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        if (shift_en)
        begin
            cnt_next   = cnt_inc;
            shift_next = shift_in;
        end
        // Drop collected bits on a bad gap, a finished packet or a lost sync.
        if (clear_bits || emit || (phase_next == PH_UNKNOWN))
        begin
            cnt_next   = '0;
            shift_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_UNKNOWN;
            cnt_reg   <= '0;
            shift_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            shift_reg <= shift_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < CNT_W'(PACKET_BITS))
        else $error("bit count reached packet length without emitting");

    a_unknown_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_UNKNOWN) |-> (cnt_reg == '0 && shift_reg == '0))
        else $error("collected bits left over in unknown phase");

    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (phase_reg == PH_END && rising))
        else $error("packet emitted outside a gap check");
`endif

endmodule

// ----- design/pulse_distance_packet_decoder.sv -----
// ----------------------------------------------------------------------------
// Pulse-distance packet decoder
// Decodes line edge timing into 36-bit MSB-first packets.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one edge per transfer: the line
//   level after the edge and the microseconds since the previous edge.
//   Output channel (out_valid/out_stall) carries one completed packet per
//   transfer; most edges produce no packet.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata):
//   tolerance, high pulse, zero gap and one gap lengths. Write only while idle.
// Timing:
//   An accepted edge sits in the input register; once it advances it runs
//   through the window compares and phase machine, and a packet it completes
//   is loaded into the output register.
//   Throughput is one edge per cycle while no stalled packet holds the output
//   register; the phase machine's compare/shift path is combinational.
// Reset: phase returns to unknown, collected bits are cleared, registers
//   return to 100/500/1000/2000 us, and both channels go empty.
// Stall: a held output packet stops the input register from advancing, so
//   in_stall rises whenever an edge sits in the input register behind a
//   stalled packet, whether or not that edge completes a packet.
// ----------------------------------------------------------------------------
module pulse_distance_packet_decoder
    import pdpd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   line_level,
    input  logic [TIME_W-1:0]      edge_interval,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [PACKET_BITS-1:0] packet,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_wdata
);

    // Configuration registers
    logic [TOL_W-1:0]  tolerance_reg;
    logic [TIME_W-1:0] high_pulse_reg;
    logic [TIME_W-1:0] zero_gap_reg;
    logic [TIME_W-1:0] one_gap_reg;

    // Input register
    logic              in_valid_reg;
    logic              level_reg;
    logic [TIME_W-1:0] interval_reg;

    // Output register
    logic                   out_valid_reg;
    logic [PACKET_BITS-1:0] packet_reg;

    logic                   accept;
    logic                   advance;
    logic                   emit;
    logic [PACKET_BITS-1:0] packet_data;
    logic                   high_ok;
    logic                   zero_ok;
    logic                   one_ok;
    pdpd_match_t            match;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg  <= TOLERANCE_RST;
            high_pulse_reg <= HIGH_PULSE_RST;
            zero_gap_reg   <= ZERO_GAP_RST;
            one_gap_reg    <= ONE_GAP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TOLERANCE:  tolerance_reg  <= cfg_wdata[TOL_W-1:0];
                REG_HIGH_PULSE: high_pulse_reg <= cfg_wdata[TIME_W-1:0];
                REG_ZERO_GAP:   zero_gap_reg   <= cfg_wdata[TIME_W-1:0];
                REG_ONE_GAP:    one_gap_reg    <= cfg_wdata[TIME_W-1:0];
                default:        ;
            endcase
        end
    end

    // Advance the held edge whenever the output register is free or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            level_reg    <= line_level;
            interval_reg <= edge_interval;
        end
    end

    pdpd_window u_high_win
    (
        .interval  (interval_reg),
        .nominal   (high_pulse_reg),
        .tolerance (tolerance_reg),
        .ok        (high_ok)
    );

    pdpd_window u_zero_win
    (
        .interval  (interval_reg),
        .nominal   (zero_gap_reg),
        .tolerance (tolerance_reg),
        .ok        (zero_ok)
    );

    pdpd_window u_one_win
    (
        .interval  (interval_reg),
        .nominal   (one_gap_reg),
        .tolerance (tolerance_reg),
        .ok        (one_ok)
    );

    assign match = '{high_ok: high_ok, zero_ok: zero_ok, one_ok: one_ok};

    pdpd_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .rising      (level_reg),
        .match       (match),
        .emit        (emit),
        .packet_data (packet_data)
    );

    // Load a finished packet; drop the valid once the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            packet_reg <= packet_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign packet    = packet_reg;

`ifndef NO_ASSERTIONS
    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && emit) |=> out_valid_reg)
        else $error("emitted packet not loaded into output register");

    a_hold_edge: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=>
            (in_valid_reg && $stable(level_reg) && $stable(interval_reg)))
        else $error("held edge lost while output stalled");
`endif

endmodule

// ----- dv/pulse_distance_packet_decoder_test.sv -----
// ----------------------------------------------------------------------------
// Pulse-distance packet decoder testbench
// Drives line edges through the valid/stall input channel, predicts each
// completed 36-bit packet with a cycle-free model of the phase machine and
// compares every packet transfer on the output channel against it. Covers
// window boundaries, every phase transition, register extremes, random
// idling on both channels and a long output hold-off.
// ----------------------------------------------------------------------------
module pulse_distance_packet_decoder_test
    import pdpd_pkg::*;
();

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_EDGES = 1500;
    localparam int STAGE_EDGES  = 250;
    localparam int MAX_TIME     = (1 << TIME_W) - 1;

    // ------------------------------------------------------------------------
    // DUT connections; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   in_valid      = 1'b0;
    logic                   line_level    = 1'b0;
    logic [TIME_W-1:0]      edge_interval = '0;
    logic                   out_stall     = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index     = REG_TOLERANCE;
    logic [CFG_W-1:0]       cfg_wdata     = '0;
    logic                   in_stall;
    logic                   out_valid;
    logic [PACKET_BITS-1:0] packet;

    pulse_distance_packet_decoder u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .line_level    (line_level),
        .edge_interval (edge_interval),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .packet        (packet),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Decoder prediction state and register copies
    // ------------------------------------------------------------------------
    logic [1:0]             dec_phase;
    int                     dec_count;
    logic [PACKET_BITS-1:0] dec_shift;
    int                     cfg_tol;
    int                     cfg_high;
    int                     cfg_zero;
    int                     cfg_one;

    // Packets predicted but not yet seen on the output, oldest first
    logic [PACKET_BITS-1:0] pending_packets[$];
    logic [PACKET_BITS-1:0] expected_packet;

    int  edges_sent   = 0;
    int  mismatches   = 0;
    int  cycle_count  = 0;
    int  idle_pct     = 0;
    int  stall_pct    = 0;
    bit  hold_request = 1'b0;
    int  hold_left    = 0;

    // Strict window: nominal - tol < t < nominal + tol, signed
    function automatic bit in_window(input int t, input int nominal);
        return (t < nominal + cfg_tol) && (t > nominal - cfg_tol);
    endfunction

    task automatic clear_collected();
        dec_count = 0;
        dec_shift = '0;
    endtask

    // Advance the predicted phase machine by one accepted edge
    task automatic predict_edge(input logic lvl, input logic [TIME_W-1:0] iv);
        int t;
        t = int'(iv);
        case (dec_phase)
            PH_START:
            begin
                // only a falling edge closing a good high pulse moves on
                if (!lvl && in_window(t, cfg_high))
                    dec_phase = PH_END;
                else
                    dec_phase = PH_UNKNOWN;
            end
            PH_END:
            begin
                if (lvl)
                begin
                    // a gap inside both windows counts as a one
                    if (in_window(t, cfg_one))
                    begin
                        dec_shift[PACKET_BITS-1-dec_count] = 1'b1;
                        dec_count++;
                    end
                    else if (in_window(t, cfg_zero))
                        dec_count++;
                    else
                        clear_collected();
                    dec_phase = PH_START;
                end
                else
                    dec_phase = PH_UNKNOWN;
            end
            default:
                // unknown, and the unused code treated the same way
                dec_phase = lvl ? PH_START : PH_UNKNOWN;
        endcase
        if (dec_count >= PACKET_BITS)
        begin
            pending_packets.push_back(dec_shift);
            clear_collected();
        end
        if (dec_phase == PH_UNKNOWN)
            clear_collected();
    endtask

    // ------------------------------------------------------------------------
    // Input side: one edge per transfer, random idle gaps before each
    // ------------------------------------------------------------------------
    task automatic send_edge(input logic lvl, input logic [TIME_W-1:0] iv);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        line_level    <= lvl;
        edge_interval <= iv;
        @(posedge clk);
        // hold the payload until the block takes it
        while (in_stall)
            @(posedge clk);
        predict_edge(lvl, iv);
        edges_sent++;
    endtask

    function automatic logic [TIME_W-1:0] random_time();
        return TIME_W'($urandom_range(0, MAX_TIME));
    endfunction

    // Pick a time inside the window around nominal, clipped to the field range
    function automatic logic [TIME_W-1:0] pick_in_window(input int nominal);
        int lo;
        int hi;
        lo = nominal - cfg_tol + 1;
        hi = nominal + cfg_tol - 1;
        if (lo < 0)
            lo = 0;
        if (hi > MAX_TIME)
            hi = MAX_TIME;
        if (lo > hi)
            return random_time();
        return TIME_W'($urandom_range(lo, hi));
    endfunction

    function automatic logic [PACKET_BITS-1:0] random_payload();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return raw[PACKET_BITS-1:0];
        endcase
    endfunction

    // Send one well-formed packet; break_at >= 0 corrupts that bit's edges
    task automatic send_packet(input logic [PACKET_BITS-1:0] payload, input int break_at);
        int i;
        // resync when not sitting right after a rising edge, and at random otherwise
        if (dec_phase != PH_START || $urandom_range(0, 1) == 0)
        begin
            send_edge(1'b0, random_time());
            send_edge(1'b1, random_time());
        end
        for (i = 0; i < PACKET_BITS; i++)
        begin
            if (i == break_at)
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    send_edge($urandom_range(0, 1) == 1, random_time());
                    send_edge(1'b1, pick_in_window(cfg_one));
                end
                else
                begin
                    send_edge(1'b0, pick_in_window(cfg_high));
                    send_edge($urandom_range(0, 1) == 1, random_time());
                end
            end
            else
            begin
                send_edge(1'b0, pick_in_window(cfg_high));
                send_edge(1'b1,
                          pick_in_window(payload[PACKET_BITS-1-i] ? cfg_one : cfg_zero));
            end
        end
    endtask

    // Random edges, half of them with times near one of the nominals
    task automatic send_noise(input int count);
        int i;
        logic [TIME_W-1:0] iv;
        for (i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 5))
                0:       iv = pick_in_window(cfg_high);
                1:       iv = pick_in_window(cfg_zero);
                2:       iv = pick_in_window(cfg_one);
                default: iv = random_time();
            endcase
            send_edge($urandom_range(0, 1) == 1, iv);
        end
    endtask

    // Drop valid, wait for every predicted packet, then let the pipe settle
    task automatic wait_drained();
        int waited;
        in_valid <= 1'b0;
        waited = 0;
        while (pending_packets.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all four registers back to back while the block is idle
    task automatic load_config(input int tol, input int high, input int zero, input int one);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= REG_TOLERANCE;
        cfg_wdata <= CFG_W'(tol);
        @(posedge clk);
        cfg_index <= REG_HIGH_PULSE;
        cfg_wdata <= CFG_W'(high);
        @(posedge clk);
        cfg_index <= REG_ZERO_GAP;
        cfg_wdata <= CFG_W'(zero);
        @(posedge clk);
        cfg_index <= REG_ONE_GAP;
        cfg_wdata <= CFG_W'(one);
        @(posedge clk);
        cfg_we   <= 1'b0;
        cfg_tol  = tol;
        cfg_high = high;
        cfg_zero = zero;
        cfg_one  = one;
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stall, or a long hold-off when requested
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Compare every packet transfer against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_packets.size() == 0)
            begin
                $display("%0t unexpected packet: expected none, actual %h", $time, packet);
                mismatches++;
            end
            else
            begin
                expected_packet = pending_packets.pop_front();
                if (packet !== expected_packet)
                begin
                    $display("%0t packet mismatch: expected %h, actual %h",
                             $time, expected_packet, packet);
                    mismatches++;
                end
            end
        end
    end

    // Guard against a hung handshake
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t timeout with %0d packets outstanding", $time, pending_packets.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset values: 100 us tolerance around 500 / 1000 / 2000 us
    task automatic test_directed_defaults();
        send_edge(1'b0, 16'd0);       // falling edge in unknown: stay
        send_edge(1'b1, 16'hFFFF);    // rising edge: pulse started
        send_edge(1'b1, 16'd500);     // rising again in started: bad pulse
        send_edge(1'b1, 16'd0);
        send_edge(1'b0, 16'd400);     // lower window bound is excluded
        send_edge(1'b1, 16'd7);
        send_edge(1'b0, 16'd600);     // upper window bound is excluded
        send_edge(1'b1, 16'd1);
        send_edge(1'b0, 16'd401);     // just inside: pulse ended
        send_edge(1'b1, 16'd1100);    // gap fits nothing: clear, restart
        send_edge(1'b0, 16'd599);
        send_edge(1'b1, 16'd1099);    // zero bit
        send_edge(1'b0, 16'd500);
        send_edge(1'b1, 16'd2099);    // one bit
        send_edge(1'b0, 16'd500);
        send_edge(1'b0, 16'd1000);    // falling after pulse end: unknown
        send_edge(1'b1, 16'd300);
        send_edge(1'b0, 16'd500);
        send_edge(1'b1, 16'd1901);    // one bit at lower edge
        send_edge(1'b0, 16'd500);
        send_edge(1'b1, 16'd901);     // zero bit at lower edge
        send_edge(1'b0, 16'd500);
        send_edge(1'b1, 16'd3000);    // bad gap drops the two bits
    endtask

    // Register extremes: zero and 1000 us tolerance, nominals at both ends
    task automatic test_window_extremes();
        load_config(0, HIGH_PULSE_RST, ZERO_GAP_RST, ONE_GAP_RST);
        send_packet(random_payload(), -1);
        send_noise(6);
        // windows overlap: gaps in both count as ones
        load_config(1000, 1, 1000, 1500);
        send_packet('1, -1);
        send_packet(random_payload(), -1);
        load_config(1, MAX_TIME, 1, MAX_TIME);
        send_packet('0, -1);
        send_packet(random_payload(), -1);
    endtask

    // Hold the output long enough that the input has to stall
    task automatic test_backpressure();
        load_config(TOLERANCE_RST, HIGH_PULSE_RST, ZERO_GAP_RST, ONE_GAP_RST);
        idle_pct     = 0;
        stall_pct    = 0;
        hold_request = 1'b1;
        repeat (3) send_packet(random_payload(), -1);
    endtask

    // Mostly well-formed packets with random content, some broken, some noise
    task automatic test_random_traffic();
        int stage;
        int stage_start;
        int goal;
        goal = edges_sent + RANDOM_EDGES;
        for (stage = 0; stage < 64 && edges_sent < goal; stage++)
        begin
            case (stage % 6)
                0: load_config(TOLERANCE_RST, HIGH_PULSE_RST, ZERO_GAP_RST, ONE_GAP_RST);
                1: load_config(1000, 500, 1000, 2000);
                2: load_config(3, 1, 2, 5);
                3: load_config(1000, MAX_TIME, 64000, MAX_TIME);
                default: load_config($urandom_range(1, 1000), $urandom_range(1, MAX_TIME),
                                     $urandom_range(1, MAX_TIME), $urandom_range(1, MAX_TIME));
            endcase
            case (stage % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 72;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 72;
                end
                default:
                begin
                    idle_pct  = 22;
                    stall_pct = 22;
                end
            endcase
            stage_start = edges_sent;
            while (edges_sent - stage_start < STAGE_EDGES)
            begin
                if ($urandom_range(0, 99) < 85)
                    send_packet(random_payload(),
                                ($urandom_range(0, 99) < 15) ?
                                    int'($urandom_range(0, PACKET_BITS - 1)) : -1);
                else
                    send_noise($urandom_range(1, 6));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        dec_phase = PH_UNKNOWN;
        dec_count = 0;
        dec_shift = '0;
        cfg_tol   = TOLERANCE_RST;
        cfg_high  = HIGH_PULSE_RST;
        cfg_zero  = ZERO_GAP_RST;
        cfg_one   = ONE_GAP_RST;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_defaults();
        test_window_extremes();
        test_backpressure();
        test_random_traffic();

        idle_pct  = 0;
        stall_pct = 0;
        wait_drained();

        if (mismatches == 0 && pending_packets.size() == 0)
            $display("Regression PASS");
        else
        begin
            if (pending_packets.size() != 0)
                $display("%0t %0d predicted packets never arrived",
                         $time, pending_packets.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/pdpd_pkg.sv
design/pdpd_window.sv
design/pdpd_core.sv
design/pulse_distance_packet_decoder.sv
dv/pulse_distance_packet_decoder_test.sv
